[hw/rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// Used by the front queue, the line engine and the top level.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] HALF_BIT_RESET = 16'd5;
    localparam logic [3:0]  LAST_DATA_BIT  = 4'd8;
    localparam logic [3:0]  LAST_SEQ_STEP  = 4'd3;

    // raw opcode field values on the input stream
    localparam logic [1:0] OPC_START = 2'd0;
    localparam logic [1:0] OPC_STOP  = 2'd1;
    localparam logic [1:0] OPC_WRITE = 2'd2;
    localparam logic [1:0] OPC_READ  = 2'd3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_kind_t;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_STOP  = 7'b0000100,
        PH_WR_LO = 7'b0001000,
        PH_WR_HI = 7'b0010000,
        PH_RD_LO = 7'b0100000,
        PH_RD_HI = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        cmd_kind_t  kind;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       ack_received;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_out;
    } tick_result_t;

endpackage

[hw/rtl/i2cm_front.sv]
// Front end: accepts tick transfers, decodes the opcode and queues the items.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    output logic        q_valid,
    output tick_item_t  q_item,
    input  logic        q_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    tick_item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  push;
    tick_item_t            in_item;

    // classify the incoming transfer
    always_comb
    begin
        in_item.cmd_valid  = s_axis_tuser[0];
        in_item.write_byte = s_axis_tdata[7:0];
        in_item.send_ack   = s_axis_tdata[8];
        in_item.sda_in     = s_axis_tdata[9];
        case (s_axis_tuser[2:1])
            OPC_START: in_item.kind = CMD_START;
            OPC_STOP:  in_item.kind = CMD_STOP;
            OPC_WRITE: in_item.kind = CMD_WRITE;
            default:   in_item.kind = CMD_READ;
        endcase
    end

    assign s_axis_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/i2cm_engine.sv]
// Back end: the SCL/SDA sequencer, one queued tick per step, with an output register.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         q_valid,
    input  tick_item_t   q_item,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output tick_result_t out_result
);

    logic [15:0]  half_ticks_reg;
    phase_t       phase_reg, phase_next;
    logic [15:0]  tick_reg, tick_next;
    logic [3:0]   bit_reg, bit_next;
    logic [7:0]   shift_reg, shift_next;
    logic         ack_flag_reg, ack_flag_next;
    logic         ack_send_reg, ack_send_next;
    logic         scl_reg, scl_next;
    logic         sda_reg, sda_next;
    logic [7:0]   last_read_reg, last_read_next;
    logic         out_valid_reg;
    tick_result_t out_result_reg;

    logic         step;
    logic         done;
    logic         drv;
    logic [15:0]  half_eff;

    assign step      = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = step;
    assign half_eff  = (half_ticks_reg == '0) ? 16'd1 : half_ticks_reg;
    assign out_valid = out_valid_reg;
    assign out_result = out_result_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        ack_flag_next  = ack_flag_reg;
        ack_send_next  = ack_send_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        drv            = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (q_item.cmd_valid)
                begin
                    tick_next = '0;
                    bit_next  = '0;
                    drv       = 1'b1;
                    case (q_item.kind)
                        CMD_START: phase_next = PH_START;
                        CMD_STOP:  phase_next = PH_STOP;
                        CMD_WRITE:
                        begin
                            phase_next = PH_WR_LO;
                            shift_next = q_item.write_byte;
                        end
                        default:
                        begin
                            phase_next    = PH_RD_LO;
                            shift_next    = '0;
                            ack_send_next = q_item.send_ack;
                        end
                    endcase
                end
            end
            else if (({1'b0, tick_reg} + 17'd1) < {1'b0, half_eff})
            begin
                tick_next = tick_reg + 1'b1;
            end
            else
            begin
                // end of a half period
                tick_next = '0;
                case (phase_reg)
                    PH_START, PH_STOP:
                    begin
                        if (bit_reg >= LAST_SEQ_STEP)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next = bit_reg + 1'b1;
                            drv      = 1'b1;
                        end
                    end
                    PH_WR_LO:
                    begin
                        phase_next = PH_WR_HI;
                        drv        = 1'b1;
                    end
                    PH_WR_HI:
                    begin
                        if (bit_reg < LAST_DATA_BIT)
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_WR_LO;
                            drv        = 1'b1;
                        end
                        else
                        begin
                            ack_flag_next = !q_item.sda_in;
                            phase_next    = PH_IDLE;
                            scl_next      = 1'b0;
                            sda_next      = 1'b1;
                            done          = 1'b1;
                        end
                    end
                    PH_RD_LO:
                    begin
                        phase_next = PH_RD_HI;
                        drv        = 1'b1;
                    end
                    PH_RD_HI:
                    begin
                        if (bit_reg < LAST_DATA_BIT)
                        begin
                            shift_next = {shift_reg[6:0], q_item.sda_in};
                            bit_next   = bit_reg + 1'b1;
                            if (bit_next == LAST_DATA_BIT)
                            begin
                                last_read_next = shift_next;
                            end
                            phase_next = PH_RD_LO;
                            drv        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end

            // set line levels for the step just entered
            if (drv)
            begin
                case (phase_next)
                    PH_START:
                    begin
                        case (bit_next)
                            4'd0: sda_next = 1'b1;
                            4'd1:
                            begin
                                scl_next = 1'b1;
                                sda_next = 1'b1;
                            end
                            4'd2:
                            begin
                                scl_next = 1'b1;
                                sda_next = 1'b0;
                            end
                            default:
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b0;
                            end
                        endcase
                    end
                    PH_STOP:
                    begin
                        case (bit_next)
                            4'd0: scl_next = 1'b0;
                            4'd1:
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b0;
                            end
                            4'd2:
                            begin
                                scl_next = 1'b1;
                                sda_next = 1'b0;
                            end
                            default:
                            begin
                                scl_next = 1'b1;
                                sda_next = 1'b1;
                            end
                        endcase
                    end
                    PH_WR_LO:
                    begin
                        scl_next = 1'b0;
                        sda_next = (bit_next < LAST_DATA_BIT) ? shift_next[7] : 1'b1;
                    end
                    PH_RD_LO:
                    begin
                        scl_next = 1'b0;
                        sda_next = (bit_next < LAST_DATA_BIT) ? 1'b1 : !ack_send_next;
                    end
                    PH_WR_HI, PH_RD_HI: scl_next = 1'b1;
                    default: scl_next = scl_next;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_ticks_reg <= HALF_BIT_RESET;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            ack_flag_reg   <= 1'b0;
            ack_send_reg   <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            last_read_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_ticks_reg <= cfg_wdata;
            end
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            ack_flag_reg  <= ack_flag_next;
            ack_send_reg  <= ack_send_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            last_read_reg <= last_read_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg.scl_out      <= scl_next;
            out_result_reg.sda_release  <= sda_next;
            out_result_reg.busy_res     <= (phase_next != PH_IDLE);
            out_result_reg.done_res     <= done;
            out_result_reg.ack_received <= ack_flag_next;
            out_result_reg.read_byte    <= last_read_next;
        end
    end

endmodule

[hw/rtl/i2c_master_bit_engine.sv]
// I2C master bit engine: one tick transfer in gives one line-state transfer out.
// Result path: the input transfer is written into the queue, then the engine step registers the result.
// Throughput: one tick per cycle while the output is not stalled; each engine step takes one queued tick.
// The tick queue (QUEUE_DEPTH entries) lets input run ahead of a stalled output.
// Reset (rst_n low, asynchronous): idle, SCL and SDA released, half period 5 ticks.
// Depends on i2cm_pkg, i2cm_front and i2cm_engine.
`timescale 1ns / 1ps

module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // half_bit_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] write_byte, [8] send_ack, [9] sda_in, rest 0
    input  logic [2:0]  s_axis_tuser,   // [0] cmd_valid, [2:1] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] scl_out, [1] sda_release, [2] busy_res,
                                        // [3] done_res, [4] ack_received, [12:5] read_byte
);

    logic         q_valid;
    tick_item_t   q_item;
    logic         q_pop;
    tick_result_t result;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    i2cm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {3'b000, result.read_byte, result.ack_received, result.done_res,
                           result.busy_res, result.sda_release, result.scl_out};

endmodule

[hw/rtl/i2cm_checker.sv]
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module i2cm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done and busy both set");

    // the queue fills only behind a stalled result
    a_full_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input blocked with no pending result");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
